[hdl/mrfc_pkg.sv]
// Shared types and constants for the motor ramp and fault controller.
package mrfc_pkg;

  localparam int SPEED_W = 16;
  localparam int POS_W   = 32;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd10000;
  localparam logic [SPEED_W-1:0] RAMP_STEP_RST = 16'd500;

  // speed / 100 as (speed * 83887) >> 23, exact over the full 16-bit range
  localparam int               DIV_MUL_W = 17;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd83887;
  localparam int               DIV_SHIFT = 23;
  localparam int               PROD_W    = SPEED_W + DIV_MUL_W;
  localparam int               QUOT_W    = PROD_W - DIV_SHIFT;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 1'd1;

  // sticky flag bit positions
  localparam int FLAG_OVERCURRENT = 0;
  localparam int FLAG_STALL       = 1;
  localparam int FLAG_OVERHEAT    = 2;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_START       = 3'd1,
    MODE_STOP        = 3'd2,
    MODE_BRAKE       = 3'd3,
    MODE_SET_SPEED   = 3'd4,
    MODE_RESET       = 3'd5,
    MODE_CLEAR_FAULT = 3'd6,
    MODE_INJECT      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_STOPPING = 3'd3,
    ST_FAULT    = 3'd4,
    ST_RECOVERY = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    FLT_NONE        = 2'd0,
    FLT_STALL       = 2'd1,
    FLT_OVERHEAT    = 2'd2,
    FLT_OVERCURRENT = 2'd3
  } fault_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [SPEED_W-1:0] speed;
    logic               direction;
    logic [1:0]         fault_kind;
    logic [2:0]         hw_fault_flags;
  } in_t;

  typedef struct packed {
    logic                    ret_code;
    logic [2:0]              motor_state;
    logic [1:0]              fault_id;
    logic [SPEED_W-1:0]      motor_speed;
    logic signed [POS_W-1:0] position;
    logic                    ctrl_enable;
    logic                    ctrl_dir_cw;
    logic                    ctrl_brake;
    logic                    status_running;
    logic [2:0]              status_faults;
  } out_t;

endpackage

[hdl/motor_ramp_fault_controller_top.sv]
// Motor ramp and fault controller: command decode, speed ramp, position and status.
//
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  input   | in_valid, in_ready, in_data     | in
//  result  | out_valid, out_ready, out_data  | out
//  config  | cfg_we, cfg_index, cfg_wdata    | in
//
// One beat per cycle sustained while out_ready is high. A command is first captured
// in the input register, then the decode, ramp and position update write the state
// and the result register when the beat advances, raising out_valid.
// Synchronous active-low reset puts the controller in idle with default limits.
// A stalled result holds the pipe; the input register still takes one beat.
module motor_ramp_fault_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mrfc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mrfc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [mrfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [mrfc_pkg::SPEED_W-1:0] max_speed_r, ramp_step_r;

  logic          in_valid_r;
  mrfc_pkg::in_t in_data_r;
  logic          out_valid_r;
  mrfc_pkg::out_t out_data_r;
  logic          adv;

  mrfc_pkg::state_t               state_r, state_nxt;
  mrfc_pkg::fault_t               fault_r, fault_nxt;
  logic [mrfc_pkg::SPEED_W-1:0]   target_r, target_nxt;
  logic [mrfc_pkg::SPEED_W-1:0]   speed_r, speed_nxt;
  logic                           dir_r, dir_nxt;
  logic signed [mrfc_pkg::POS_W-1:0] position_r, position_nxt;
  logic [2:0]                     flags_r, flags_nxt;
  logic                           enable_r, enable_nxt;
  logic                           dir_cw_r, dir_cw_nxt;
  logic                           brake_r, brake_nxt;
  logic                           running_r, running_nxt;
  logic                           ret_nxt;

  logic [mrfc_pkg::SPEED_W-1:0]   sat_speed;
  logic [2:0]                     tick_flags;
  logic [mrfc_pkg::SPEED_W:0]     ramp_sum;
  logic [mrfc_pkg::SPEED_W-1:0]   ramp_diff;
  logic [mrfc_pkg::SPEED_W-1:0]   run_speed;
  logic [mrfc_pkg::PROD_W-1:0]    div_prod;
  logic [mrfc_pkg::QUOT_W-1:0]    pos_step;
  logic signed [mrfc_pkg::POS_W-1:0] pos_delta;

  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sat_speed  = (in_data_r.speed > max_speed_r) ? max_speed_r : in_data_r.speed;
  assign tick_flags = flags_r | in_data_r.hw_fault_flags;
  assign ramp_sum   = {1'b0, speed_r} + {1'b0, ramp_step_r};
  assign ramp_diff  = speed_r - target_r;

  always_comb begin
    if (speed_r < target_r) begin
      run_speed = (ramp_sum > {1'b0, target_r}) ? target_r : ramp_sum[mrfc_pkg::SPEED_W-1:0];
    end else if (speed_r > target_r) begin
      run_speed = (ramp_diff <= ramp_step_r) ? target_r : speed_r - ramp_step_r;
    end else begin
      run_speed = speed_r;
    end
  end

  assign div_prod  = {{mrfc_pkg::DIV_MUL_W{1'b0}}, run_speed} *
                     {{mrfc_pkg::SPEED_W{1'b0}}, mrfc_pkg::DIV_MUL};
  assign pos_step  = div_prod[mrfc_pkg::PROD_W-1:mrfc_pkg::DIV_SHIFT];
  assign pos_delta = $signed({{(mrfc_pkg::POS_W-mrfc_pkg::QUOT_W){1'b0}}, pos_step});

  always_comb begin
    state_nxt    = state_r;
    fault_nxt    = fault_r;
    target_nxt   = target_r;
    speed_nxt    = speed_r;
    dir_nxt      = dir_r;
    position_nxt = position_r;
    flags_nxt    = flags_r;
    enable_nxt   = enable_r;
    dir_cw_nxt   = dir_cw_r;
    brake_nxt    = brake_r;
    running_nxt  = running_r;
    ret_nxt      = 1'b0;
    case (mrfc_pkg::mode_t'(in_data_r.mode))
      mrfc_pkg::MODE_TICK: begin
        flags_nxt = tick_flags;
        if (tick_flags != 3'd0) begin
          if (state_r != mrfc_pkg::ST_FAULT) begin
            state_nxt = mrfc_pkg::ST_FAULT;
            if (tick_flags[mrfc_pkg::FLAG_STALL]) begin
              fault_nxt = mrfc_pkg::FLT_STALL;
            end else if (tick_flags[mrfc_pkg::FLAG_OVERHEAT]) begin
              fault_nxt = mrfc_pkg::FLT_OVERHEAT;
            end else begin
              fault_nxt = mrfc_pkg::FLT_OVERCURRENT;
            end
          end
        end else begin
          case (state_r)
            mrfc_pkg::ST_STARTING: begin
              running_nxt = 1'b1;
              if (speed_r < target_r) begin
                if (ramp_sum >= {1'b0, target_r}) begin
                  speed_nxt = target_r;
                  state_nxt = mrfc_pkg::ST_RUNNING;
                end else begin
                  speed_nxt = ramp_sum[mrfc_pkg::SPEED_W-1:0];
                end
              end else begin
                state_nxt = mrfc_pkg::ST_RUNNING;
              end
            end
            mrfc_pkg::ST_RUNNING: begin
              speed_nxt    = run_speed;
              position_nxt = dir_r ? position_r + pos_delta : position_r - pos_delta;
            end
            mrfc_pkg::ST_STOPPING: begin
              if (speed_r > ramp_step_r) begin
                speed_nxt = speed_r - ramp_step_r;
              end else begin
                speed_nxt   = '0;
                state_nxt   = mrfc_pkg::ST_IDLE;
                running_nxt = 1'b0;
              end
            end
            mrfc_pkg::ST_RECOVERY: state_nxt = mrfc_pkg::ST_IDLE;
            default: ;
          endcase
        end
      end
      mrfc_pkg::MODE_START: begin
        if (state_r == mrfc_pkg::ST_FAULT) begin
          ret_nxt = 1'b1;
        end else begin
          target_nxt = sat_speed;
          dir_nxt    = in_data_r.direction;
          state_nxt  = mrfc_pkg::ST_STARTING;
          enable_nxt = 1'b1;
          dir_cw_nxt = in_data_r.direction;
          brake_nxt  = 1'b0;
        end
      end
      mrfc_pkg::MODE_STOP: begin
        if (state_r != mrfc_pkg::ST_IDLE) begin
          target_nxt = '0;
          state_nxt  = mrfc_pkg::ST_STOPPING;
          enable_nxt = 1'b0;
        end
      end
      mrfc_pkg::MODE_BRAKE: begin
        target_nxt  = '0;
        speed_nxt   = '0;
        state_nxt   = mrfc_pkg::ST_IDLE;
        brake_nxt   = 1'b1;
        enable_nxt  = 1'b0;
        running_nxt = 1'b0;
      end
      mrfc_pkg::MODE_SET_SPEED: begin
        if (state_r == mrfc_pkg::ST_FAULT) begin
          ret_nxt = 1'b1;
        end else begin
          target_nxt = sat_speed;
        end
      end
      mrfc_pkg::MODE_RESET: begin
        enable_nxt  = 1'b0;
        dir_cw_nxt  = 1'b0;
        brake_nxt   = 1'b0;
        flags_nxt   = 3'd0;
        running_nxt = 1'b0;
        state_nxt   = mrfc_pkg::ST_IDLE;
        fault_nxt   = mrfc_pkg::FLT_NONE;
        speed_nxt   = '0;
        target_nxt  = '0;
      end
      mrfc_pkg::MODE_CLEAR_FAULT: begin
        if (state_r == mrfc_pkg::ST_FAULT) begin
          fault_nxt   = mrfc_pkg::FLT_NONE;
          state_nxt   = mrfc_pkg::ST_RECOVERY;
          flags_nxt   = 3'd0;
          running_nxt = 1'b0;
        end
      end
      mrfc_pkg::MODE_INJECT: begin
        fault_nxt = mrfc_pkg::fault_t'(in_data_r.fault_kind);
        state_nxt = mrfc_pkg::ST_FAULT;
        case (mrfc_pkg::fault_t'(in_data_r.fault_kind))
          mrfc_pkg::FLT_STALL:       flags_nxt[mrfc_pkg::FLAG_STALL]       = 1'b1;
          mrfc_pkg::FLT_OVERHEAT:    flags_nxt[mrfc_pkg::FLAG_OVERHEAT]    = 1'b1;
          mrfc_pkg::FLT_OVERCURRENT: flags_nxt[mrfc_pkg::FLAG_OVERCURRENT] = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= mrfc_pkg::MAX_SPEED_RST;
      ramp_step_r <= mrfc_pkg::RAMP_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrfc_pkg::REG_MAX_SPEED: max_speed_r <= cfg_wdata;
        mrfc_pkg::REG_RAMP_STEP: ramp_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= mrfc_pkg::ST_IDLE;
      fault_r     <= mrfc_pkg::FLT_NONE;
      target_r    <= '0;
      speed_r     <= '0;
      dir_r       <= 1'b0;
      position_r  <= '0;
      flags_r     <= 3'd0;
      enable_r    <= 1'b0;
      dir_cw_r    <= 1'b0;
      brake_r     <= 1'b0;
      running_r   <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        state_r    <= state_nxt;
        fault_r    <= fault_nxt;
        target_r   <= target_nxt;
        speed_r    <= speed_nxt;
        dir_r      <= dir_nxt;
        position_r <= position_nxt;
        flags_r    <= flags_nxt;
        enable_r   <= enable_nxt;
        dir_cw_r   <= dir_cw_nxt;
        brake_r    <= brake_nxt;
        running_r  <= running_nxt;
        out_data_r.ret_code       <= ret_nxt;
        out_data_r.motor_state    <= state_nxt;
        out_data_r.fault_id       <= fault_nxt;
        out_data_r.motor_speed    <= speed_nxt;
        out_data_r.position       <= position_nxt;
        out_data_r.ctrl_enable    <= enable_nxt;
        out_data_r.ctrl_dir_cw    <= dir_cw_nxt;
        out_data_r.ctrl_brake     <= brake_nxt;
        out_data_r.status_running <= running_nxt;
        out_data_r.status_faults  <= flags_nxt;
      end
    end
  end

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced beat did not reach the result register");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_running_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrfc_pkg::ST_RUNNING) |-> running_r)
    else $error("running state without running status bit");

endmodule

[tb/tb_motor_ramp_fault_controller_top.sv]
// Self-checking testbench for the motor ramp and fault controller top level.
module tb_motor_ramp_fault_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    mrfc_pkg::in_t  cmd;
    bit             typed;
    mrfc_pkg::out_t want;
  } step_row_t;

  typedef struct {
    logic [mrfc_pkg::SPEED_W-1:0] spd_lim;
    logic [mrfc_pkg::SPEED_W-1:0] ramp;
    int                           items;
  } cfg_phase_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  mrfc_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  mrfc_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [mrfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mrfc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  motor_ramp_fault_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // controller shadow state
  logic [mrfc_pkg::SPEED_W-1:0] lim_max, lim_step;
  mrfc_pkg::state_t             m_state;
  mrfc_pkg::fault_t             m_fault;
  logic [mrfc_pkg::SPEED_W-1:0] m_target, m_speed;
  logic                         m_dir;
  logic [mrfc_pkg::POS_W-1:0]   m_pos;
  logic [2:0]                   m_flags;
  logic                         m_en, m_cw, m_brk, m_run;

  mrfc_pkg::out_t status_q[$];
  int   n_sent, n_bad, idle_run;
  int   snd_idle, rcv_idle;
  bit   hold_off_req;

  task automatic reset_model();
    lim_max  = mrfc_pkg::MAX_SPEED_RST;
    lim_step = mrfc_pkg::RAMP_STEP_RST;
    m_state  = mrfc_pkg::ST_IDLE;
    m_fault  = mrfc_pkg::FLT_NONE;
    m_target = '0;
    m_speed  = '0;
    m_dir    = 1'b0;
    m_pos    = '0;
    m_flags  = '0;
    {m_en, m_cw, m_brk, m_run} = '0;
  endtask

  function automatic logic [mrfc_pkg::SPEED_W-1:0] clamp_speed(
      logic [mrfc_pkg::SPEED_W-1:0] v);
    return (v > lim_max) ? lim_max : v;
  endfunction

  function automatic mrfc_pkg::out_t predict_status(mrfc_pkg::in_t c);
    mrfc_pkg::out_t r;
    int unsigned    s, t, stp;
    bit             refused;
    refused = 1'b0;
    stp     = 32'(lim_step);
    case (c.mode)
      mrfc_pkg::MODE_TICK: begin
        m_flags = m_flags | c.hw_fault_flags;
        if (m_flags != '0) begin
          if (m_state != mrfc_pkg::ST_FAULT) begin
            m_state = mrfc_pkg::ST_FAULT;
            if (m_flags[mrfc_pkg::FLAG_STALL]) m_fault = mrfc_pkg::FLT_STALL;
            else if (m_flags[mrfc_pkg::FLAG_OVERHEAT]) m_fault = mrfc_pkg::FLT_OVERHEAT;
            else m_fault = mrfc_pkg::FLT_OVERCURRENT;
          end
        end else begin
          s = 32'(m_speed);
          t = 32'(m_target);
          case (m_state)
            mrfc_pkg::ST_STARTING: begin
              if (s < t) begin
                s = s + stp;
                if (s >= t) begin
                  s = t;
                  m_state = mrfc_pkg::ST_RUNNING;
                end
              end else begin
                m_state = mrfc_pkg::ST_RUNNING;
              end
              m_run = 1'b1;
            end
            mrfc_pkg::ST_RUNNING: begin
              if (s < t) begin
                s = s + stp;
                if (s > t) s = t;
              end else if (s > t) begin
                s = (s - t <= stp) ? t : s - stp;
              end
              if (m_dir) m_pos = m_pos + s / 100;
              else m_pos = m_pos - s / 100;
            end
            mrfc_pkg::ST_STOPPING: begin
              if (s > stp) begin
                s = s - stp;
              end else begin
                s = 0;
                m_state = mrfc_pkg::ST_IDLE;
                m_run = 1'b0;
              end
            end
            mrfc_pkg::ST_RECOVERY: m_state = mrfc_pkg::ST_IDLE;
            default: ;
          endcase
          m_speed = s[mrfc_pkg::SPEED_W-1:0];
        end
      end
      mrfc_pkg::MODE_START: begin
        if (m_state == mrfc_pkg::ST_FAULT) begin
          refused = 1'b1;
        end else begin
          m_target = clamp_speed(c.speed);
          m_dir    = c.direction;
          m_state  = mrfc_pkg::ST_STARTING;
          m_en     = 1'b1;
          m_cw     = c.direction;
          m_brk    = 1'b0;
        end
      end
      mrfc_pkg::MODE_STOP: begin
        if (m_state != mrfc_pkg::ST_IDLE) begin
          m_target = '0;
          m_state  = mrfc_pkg::ST_STOPPING;
          m_en     = 1'b0;
        end
      end
      mrfc_pkg::MODE_BRAKE: begin
        m_target = '0;
        m_speed  = '0;
        m_state  = mrfc_pkg::ST_IDLE;
        m_brk    = 1'b1;
        m_en     = 1'b0;
        m_run    = 1'b0;
      end
      mrfc_pkg::MODE_SET_SPEED: begin
        if (m_state == mrfc_pkg::ST_FAULT) refused = 1'b1;
        else m_target = clamp_speed(c.speed);
      end
      mrfc_pkg::MODE_RESET: begin
        {m_en, m_cw, m_brk, m_run} = '0;
        m_flags  = '0;
        m_state  = mrfc_pkg::ST_IDLE;
        m_fault  = mrfc_pkg::FLT_NONE;
        m_speed  = '0;
        m_target = '0;
      end
      mrfc_pkg::MODE_CLEAR_FAULT: begin
        if (m_state == mrfc_pkg::ST_FAULT) begin
          m_fault = mrfc_pkg::FLT_NONE;
          m_state = mrfc_pkg::ST_RECOVERY;
          m_flags = '0;
          m_run   = 1'b0;
        end
      end
      default: begin
        m_fault = mrfc_pkg::fault_t'(c.fault_kind);
        m_state = mrfc_pkg::ST_FAULT;
        case (c.fault_kind)
          mrfc_pkg::FLT_STALL:       m_flags[mrfc_pkg::FLAG_STALL] = 1'b1;
          mrfc_pkg::FLT_OVERHEAT:    m_flags[mrfc_pkg::FLAG_OVERHEAT] = 1'b1;
          mrfc_pkg::FLT_OVERCURRENT: m_flags[mrfc_pkg::FLAG_OVERCURRENT] = 1'b1;
          default: ;
        endcase
      end
    endcase
    r.ret_code       = refused;
    r.motor_state    = m_state;
    r.fault_id       = m_fault;
    r.motor_speed    = m_speed;
    r.position       = m_pos;
    r.ctrl_enable    = m_en;
    r.ctrl_dir_cw    = m_cw;
    r.ctrl_brake     = m_brk;
    r.status_running = m_run;
    r.status_faults  = m_flags;
    return r;
  endfunction

  function automatic string fmt_status(mrfc_pkg::out_t s);
    return $sformatf("ret=%0d st=%0d flt=%0d spd=%0d pos=%0d ctl=%b%b%b run=%b flg=%b",
                     s.ret_code, s.motor_state, s.fault_id, s.motor_speed, s.position,
                     s.ctrl_enable, s.ctrl_dir_cw, s.ctrl_brake, s.status_running,
                     s.status_faults);
  endfunction

  task automatic check_status(mrfc_pkg::out_t got);
    mrfc_pkg::out_t want;
    if (status_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("status beat with nothing pending: %s", fmt_status(got));
    end else begin
      want = status_q.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("status mismatch exp: %s", fmt_status(want));
          $display("                got: %s", fmt_status(got));
        end
      end
    end
  endtask

  function automatic step_row_t row(mrfc_pkg::mode_t m, logic [mrfc_pkg::SPEED_W-1:0] spd,
                                    bit d, logic [1:0] k, logic [2:0] hw,
                                    bit typed = 1'b0, mrfc_pkg::out_t want = '0);
    step_row_t r;
    r.cmd.mode           = m;
    r.cmd.speed          = spd;
    r.cmd.direction      = d;
    r.cmd.fault_kind     = k;
    r.cmd.hw_fault_flags = hw;
    r.typed              = typed;
    r.want               = want;
    return r;
  endfunction

  function automatic logic [mrfc_pkg::SPEED_W-1:0] pick_speed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return (mrfc_pkg::SPEED_W)'($urandom_range(65535));
      default: return (mrfc_pkg::SPEED_W)'($urandom_range(lim_max));
    endcase
  endfunction

  function automatic mrfc_pkg::in_t rand_cmd(mrfc_pkg::mode_t m);
    mrfc_pkg::in_t c;
    c.mode           = m;
    c.speed          = pick_speed();
    c.direction      = 1'($urandom_range(1));
    c.fault_kind     = 2'($urandom_range(3));
    c.hw_fault_flags = 3'($urandom_range(7));
    return c;
  endfunction

  function automatic mrfc_pkg::in_t tick_cmd();
    mrfc_pkg::in_t c;
    c = rand_cmd(mrfc_pkg::MODE_TICK);
    c.hw_fault_flags = ($urandom_range(29) == 0) ? 3'($urandom_range(7, 1)) : 3'd0;
    return c;
  endfunction

  task automatic push_cmd(mrfc_pkg::in_t c, bit typed = 1'b0, mrfc_pkg::out_t want = '0);
    mrfc_pkg::out_t pred;
    snd_idle = (n_sent < 600) ? 22 : (n_sent < 1200) ? 87 : 0;
    rcv_idle = (n_sent < 600) ? 87 : (n_sent < 1200) ? 22 : 0;
    if (n_sent == 400 || n_sent == 1300) hold_off_req = 1'b1;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    pred = predict_status(c);
    status_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic drain_status();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [mrfc_pkg::SPEED_W-1:0] spd_lim,
                           logic [mrfc_pkg::SPEED_W-1:0] ramp);
    cfg_we    <= 1'b1;
    cfg_index <= mrfc_pkg::REG_MAX_SPEED;
    cfg_wdata <= spd_lim;
    @(posedge clk);
    cfg_index <= mrfc_pkg::REG_RAMP_STEP;
    cfg_wdata <= ramp;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_max  = spd_lim;
    lim_step = ramp;
  endtask

  task automatic run_profile();
    if (m_state == mrfc_pkg::ST_FAULT && $urandom_range(3) != 0)
      push_cmd(rand_cmd(mrfc_pkg::MODE_CLEAR_FAULT));
    push_cmd(rand_cmd(mrfc_pkg::MODE_START));
    repeat ($urandom_range(25, 3)) push_cmd(tick_cmd());
    if ($urandom_range(2) == 0) begin
      push_cmd(rand_cmd(mrfc_pkg::MODE_SET_SPEED));
      repeat ($urandom_range(15, 2)) push_cmd(tick_cmd());
    end
    case ($urandom_range(5))
      0, 1, 2: begin
        push_cmd(rand_cmd(mrfc_pkg::MODE_STOP));
        repeat ($urandom_range(25, 2)) push_cmd(tick_cmd());
      end
      3: push_cmd(rand_cmd(mrfc_pkg::MODE_BRAKE));
      4: begin
        push_cmd(rand_cmd(mrfc_pkg::MODE_INJECT));
        push_cmd(tick_cmd());
        push_cmd(rand_cmd(mrfc_pkg::MODE_START));
        push_cmd(rand_cmd(mrfc_pkg::MODE_CLEAR_FAULT));
        push_cmd(tick_cmd());
      end
      default: push_cmd(rand_cmd(mrfc_pkg::MODE_RESET));
    endcase
  endtask

  // result side
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_status(out_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // watchdog on handshake progress
  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("motor_ramp_fault_controller_top verification failed");
    $finish;
  end

  initial begin
    step_row_t      script[$];
    cfg_phase_t     plan[7];
    mrfc_pkg::out_t w;
    int             stop_at;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    n_sent       = 0;
    n_bad        = 0;
    snd_idle     = 22;
    rcv_idle     = 87;
    hold_off_req = 1'b0;
    reset_model();
    plan = '{'{16'hFFFF, 16'hFFFF, 250}, '{16'd0, 16'd1, 120}, '{16'd3000, 16'd250, 350},
             '{16'hFFFF, 16'd1000, 350}, '{16'd10000, 16'd0, 60},
             '{16'd1200, 16'd7, 300}, '{16'd40000, 16'd2500, 300}};

    w = '0;
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0, 1'b1, w));
    // flags ignored outside tick; stop and clear are no-ops here
    script.push_back(row(mrfc_pkg::MODE_STOP, 16'd0, 1'b1, 2'd3, 3'd7, 1'b1, w));
    script.push_back(row(mrfc_pkg::MODE_CLEAR_FAULT, 16'd0, 1'b0, 2'd1, 3'd7, 1'b1, w));
    script.push_back(row(mrfc_pkg::MODE_SET_SPEED, 16'hFFFF, 1'b0, 2'd0, 3'd5, 1'b1, w));
    w.motor_state = mrfc_pkg::ST_STARTING;
    w.ctrl_enable = 1'b1;
    w.ctrl_dir_cw = 1'b1;
    script.push_back(row(mrfc_pkg::MODE_START, 16'hFFFF, 1'b1, 2'd0, 3'd0, 1'b1, w));
    w.motor_speed    = mrfc_pkg::RAMP_STEP_RST;
    w.status_running = 1'b1;
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0, 1'b1, w));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_SET_SPEED, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_SET_SPEED, 16'd40000, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd1));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd6));
    script.push_back(row(mrfc_pkg::MODE_START, 16'd2000, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_SET_SPEED, 16'd2000, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_STOP, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_CLEAR_FAULT, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_INJECT, 16'd0, 1'b0, mrfc_pkg::FLT_NONE, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_TICK, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_BRAKE, 16'd0, 1'b0, 2'd0, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_INJECT, 16'd0, 1'b0, mrfc_pkg::FLT_OVERCURRENT, 3'd0));
    script.push_back(row(mrfc_pkg::MODE_RESET, 16'd0, 1'b0, 2'd0, 3'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) push_cmd(script[i].cmd, script[i].typed, script[i].want);
    drain_status();

    foreach (plan[p]) begin
      write_cfg(plan[p].spd_lim, plan[p].ramp);
      stop_at = n_sent + plan[p].items;
      while (n_sent < stop_at) begin
        if ($urandom_range(9) < 7) run_profile();
        else push_cmd(rand_cmd(mrfc_pkg::mode_t'(3'($urandom_range(7)))));
      end
      drain_status();
    end

    if (n_bad == 0) begin
      $display("motor_ramp_fault_controller_top verification clean");
    end else begin
      $display("motor_ramp_fault_controller_top verification failed");
    end
    $finish;
  end

endmodule
